### hw/rtl/bpfa_pkg.sv
package bpfa_pkg;

  // page geometry
  localparam int PAGE_COUNT = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
  localparam int OFFS_W     = $clog2(PAGE_BYTES);

  // mark store organization: one bit per page, packed into words
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_COUNT = PAGE_COUNT / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(WORD_COUNT);
  localparam int CNT_W      = WORD_IDX_W + 1;

  // payload widths
  localparam int OPCODE_W   = 2;
  localparam int ADDR_IN_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int ADDR_OUT_W = 22;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE      = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MARK_USED = 2'd2;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // lowest clear bit of a mark word
  function automatic logic [BIT_W-1:0] find_first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/bpfa_if.sv
interface bpfa_req_if import bpfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [ADDR_IN_W-1:0] page_address;

  modport source (output valid, opcode, page_address, input ready);
  modport sink   (input valid, opcode, page_address, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ADDR_OUT_W-1:0] allocated_address;

  modport source (output valid, status, allocated_address, input ready);
  modport sink   (input valid, status, allocated_address, output ready);
endinterface

### hw/rtl/bpfa_ram.sv
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/bitmap_page_frame_allocator.sv
// Next-fit page frame allocator over a bitmap of page used marks.
// Requests come in on req (opcode, page_address) and each one gives exactly
// one word on rsp (status, allocated_address), in request order.
// Allocate scans the mark store from the next-fit pointer, one 32-page word
// per cycle, wrapping once, marks the first free page used and returns its
// byte address; free and mark-used clear or set the mark of the page that
// holds page_address, and a page beyond the last one is reported, not touched.
// From request accept, free and mark-used pass through S_MODIFY to
// S_RESULT, an out-of-range page or an unused opcode goes straight to
// S_RESULT, and allocate stays in S_SCAN for the start word and up to 32
// further words before S_RESULT. The scan rate is set by the single
// read port of the mark RAM. One request is in work at a time; req.ready is
// high again the cycle after the response is loaded into the output register.
// The output register holds a response while rsp.ready is low; the next
// request may be accepted and worked on meanwhile, and its response waits
// for the output register to empty.
// Reset clears the pointer and a per-word valid bit, so every page reads as
// free right away; there is no clearing pass.
module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input logic        clk,
  input logic        rst,
  bpfa_req_if.sink   req,
  bpfa_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_MODIFY = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                  state;
  logic [OPCODE_W-1:0]     op;
  logic [WORD_IDX_W-1:0]   cur_word;
  logic [BIT_W-1:0]        addr_bit;
  logic [PAGE_IDX_W-1:0]   ptr;
  logic [CNT_W-1:0]        cnt;
  logic [WORD_COUNT-1:0]   word_valid;
  logic [STATUS_W-1:0]     res_status;
  logic [ADDR_OUT_W-1:0]   res_addr;
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [ADDR_OUT_W-1:0]   out_addr;

  logic [WORD_IDX_W-1:0]   rd_word;
  logic [WORD_BITS-1:0]    rd_data;
  logic [WORD_BITS-1:0]    data;
  logic [WORD_BITS-1:0]    low_mask;
  logic [WORD_BITS-1:0]    scan_word;
  logic                    found;
  logic [BIT_W-1:0]        fbit;
  logic [PAGE_IDX_W-1:0]   found_page;
  logic [WORD_BITS-1:0]    bit_sel;
  logic                    wr_en;
  logic [WORD_BITS-1:0]    wr_data;
  logic                    in_range;
  logic                    out_load;

  assign req.ready             = (state == S_IDLE);
  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.allocated_address = out_addr;

  // read address: start word on accept, following word while scanning
  always_comb begin
    if (state == S_IDLE) begin
      if (req.opcode == OP_ALLOC) begin
        rd_word = ptr[PAGE_IDX_W-1:BIT_W];
      end else begin
        rd_word = req.page_address[OFFS_W+BIT_W +: WORD_IDX_W];
      end
    end else begin
      rd_word = cur_word + 1'b1;
    end
  end

  assign in_range = ((req.page_address >> (OFFS_W + PAGE_IDX_W)) == '0);

  // never-written words read as all free
  assign data = word_valid[cur_word] ? rd_data : '0;

  // first word ignores pages below the pointer, the wrap revisit the rest
  assign low_mask = (WORD_BITS'(1) << ptr[BIT_W-1:0]) - WORD_BITS'(1);

  always_comb begin
    if (cnt == '0) begin
      scan_word = data | low_mask;
    end else if (cnt == CNT_W'(WORD_COUNT)) begin
      scan_word = data | ~low_mask;
    end else begin
      scan_word = data;
    end
  end

  assign found      = ~&scan_word;
  assign fbit       = find_first_zero(scan_word);
  assign found_page = {cur_word, fbit};

  // mark write-back
  always_comb begin
    bit_sel = '0;
    wr_en   = 1'b0;
    wr_data = data;
    if (state == S_SCAN && found) begin
      bit_sel = WORD_BITS'(1) << fbit;
      wr_en   = 1'b1;
      wr_data = data | bit_sel;
    end else if (state == S_MODIFY) begin
      bit_sel = WORD_BITS'(1) << addr_bit;
      wr_en   = 1'b1;
      wr_data = (op == OP_MARK_USED) ? (data | bit_sel) : (data & ~bit_sel);
    end
  end

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_marks (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_word),
    .wr_data (wr_data),
    .rd_addr (rd_word),
    .rd_data (rd_data)
  );

  assign out_load = (state == S_RESULT) && (!out_valid || rsp.ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  // per-word valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[cur_word] <= 1'b1;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op       <= req.opcode;
            cur_word <= rd_word;
            addr_bit <= req.page_address[OFFS_W +: BIT_W];
            cnt      <= '0;
            res_addr <= '0;
            unique case (req.opcode) inside
              OP_ALLOC: begin
                state <= S_SCAN;
              end
              OP_FREE, OP_MARK_USED: begin
                if (in_range) begin
                  state <= S_MODIFY;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_RESULT;
                end
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_RESULT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (found) begin
            ptr        <= found_page + 1'b1;
            res_status <= ST_DONE;
            res_addr   <= ADDR_OUT_W'({found_page, {OFFS_W{1'b0}}});
            state      <= S_RESULT;
          end else if (cnt == CNT_W'(WORD_COUNT)) begin
            res_status <= ST_FULL;
            state      <= S_RESULT;
          end else begin
            cnt      <= cnt + 1'b1;
            cur_word <= cur_word + 1'b1;
          end
        end
        S_MODIFY: begin
          res_status <= ST_DONE;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
